FILE: hw/rtl/dbtw_pkg.sv
// Shared constants, codes and types of the depth buffer test-write block.
package dbtw_pkg;

    // Store geometry.
    localparam int MAX_WIDTH   = 512;
    localparam int MAX_HEIGHT  = 512;
    localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int STORE_AW    = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

    // Widths of effective dimensions (hold MAX itself) and of pixel indexes.
    localparam int XDIM_W = $clog2(MAX_WIDTH + 1);
    localparam int YDIM_W = $clog2(MAX_HEIGHT + 1);
    localparam int XIDX_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int YIDX_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

    // Field widths.
    localparam int REQ_W      = 2;
    localparam int PIX_W      = 12;
    localparam int DIN_W      = 26;
    localparam int COORD_W    = 18;
    localparam int DEPTH_W    = 25;
    localparam int CFG_DIM_W  = 10;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 25;

    // Depth of 1.0 with 24 fraction bits.
    localparam logic [DEPTH_W-1:0] DEPTH_ONE = DEPTH_W'(16777216);

    // Half a pixel in Q16 for round to nearest.
    localparam int HALF_Q16 = 32768;
    localparam int FRAC_Q16 = 16;

    // Request codes.
    localparam logic [REQ_W-1:0] REQ_WRITE  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_READ   = 2'd1;
    localparam logic [REQ_W-1:0] REQ_SAMPLE = 2'd2;
    localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH_IN_USE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT_IN_USE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CLEAR_DEPTH   = 2'd2;

    // One held request.
    typedef struct packed {
        logic [REQ_W-1:0]          req_type;
        logic signed [PIX_W-1:0]   pix_x;
        logic signed [PIX_W-1:0]   pix_y;
        logic signed [DIN_W-1:0]   depth_in;
        logic signed [COORD_W-1:0] coord_u;
        logic signed [COORD_W-1:0] coord_v;
    } req_pkt_t;

    // Step enables for the address mapper.
    typedef struct packed {
        logic mul_en;
        logic coord_en;
        logic addr_en;
    } map_ctl_t;

    // Address mapper result.
    typedef struct packed {
        logic [STORE_AW-1:0] addr;
        logic                in_area;
    } map_res_t;

    // Single-port store access.
    typedef struct packed {
        logic                wr_en;
        logic                rd_en;
        logic [STORE_AW-1:0] addr;
        logic [DEPTH_W-1:0]  wr_data;
    } mem_ctl_t;

endpackage

FILE: hw/rtl/dbtw_if.sv
// Request and response channel interfaces of the depth buffer block.
interface dbtw_req_if
    import dbtw_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic [REQ_W-1:0]          req_type;
    logic signed [PIX_W-1:0]   pix_x;
    logic signed [PIX_W-1:0]   pix_y;
    logic signed [DIN_W-1:0]   depth_in;
    logic signed [COORD_W-1:0] coord_u;
    logic signed [COORD_W-1:0] coord_v;

    modport source (
        output valid, req_type, pix_x, pix_y, depth_in, coord_u, coord_v,
        input  ready
    );

    modport sink (
        input  valid, req_type, pix_x, pix_y, depth_in, coord_u, coord_v,
        output ready
    );
endinterface

interface dbtw_rsp_if
    import dbtw_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [DEPTH_W-1:0] depth_out;
    logic               write_done;
    logic               pixel_in_range;

    modport source (
        output valid, depth_out, write_done, pixel_in_range,
        input  ready
    );

    modport sink (
        input  valid, depth_out, write_done, pixel_in_range,
        output ready
    );
endinterface

FILE: hw/rtl/dbtw_map.sv
// Pixel and sample coordinate mapping to a store address, in three steps.
module dbtw_map
    import dbtw_pkg::*;
(
    input  logic              clk,
    input  map_ctl_t          ctl,
    input  req_pkt_t          req_q,
    input  logic [XDIM_W-1:0] eff_w,
    input  logic [YDIM_W-1:0] eff_h,
    output map_res_t          res
);
    localparam int PRODU_W = COORD_W + XDIM_W + 1;
    localparam int PRODV_W = COORD_W + YDIM_W + 1;
    localparam int PU_W    = PRODU_W + 1 - FRAC_Q16;
    localparam int PV_W    = PRODV_W + 1 - FRAC_Q16;
    localparam int CMPU_W  = (PU_W > XDIM_W) ? PU_W : XDIM_W;
    localparam int CMPV_W  = (PV_W > YDIM_W) ? PV_W : YDIM_W;
    localparam int AFULL_W = YIDX_W + XDIM_W + 1;

    logic [XDIM_W-1:0]         wm1;
    logic [YDIM_W-1:0]         hm1;
    logic signed [XDIM_W:0]    wm1_s;
    logic signed [YDIM_W:0]    hm1_s;
    logic signed [PRODU_W-1:0] prod_u_reg;
    logic signed [PRODV_W-1:0] prod_v_reg;
    logic signed [PRODU_W:0]   sum_u;
    logic signed [PRODV_W:0]   sum_v;
    logic [PU_W-1:0]           pu;
    logic [PV_W-1:0]           pv;
    logic [XIDX_W-1:0]         sx;
    logic [YIDX_W-1:0]         sy;
    logic                      pix_inside;
    logic [XIDX_W-1:0]         x_reg;
    logic [XIDX_W-1:0]         x_next;
    logic [YIDX_W-1:0]         y_reg;
    logic [YIDX_W-1:0]         y_next;
    logic                      inside_reg;
    logic                      inside_next;
    logic [AFULL_W-1:0]        addr_full;
    logic [STORE_AW-1:0]       addr_reg;

    assign wm1   = eff_w - XDIM_W'(1);
    assign hm1   = eff_h - YDIM_W'(1);
    assign wm1_s = $signed({1'b0, wm1});
    assign hm1_s = $signed({1'b0, hm1});

    // Step one: scale the sample coordinates by the last pixel index.
    always_ff @(posedge clk)
    begin
        if (ctl.mul_en)
        begin
            prod_u_reg <= PRODU_W'(req_q.coord_u) * PRODU_W'(wm1_s);
            prod_v_reg <= PRODV_W'(req_q.coord_v) * PRODV_W'(hm1_s);
        end
    end

    // Round to nearest, then clamp into the active area.
    always_comb
    begin
        sum_u = (PRODU_W + 1)'(prod_u_reg) + (PRODU_W + 1)'(HALF_Q16);
        sum_v = (PRODV_W + 1)'(prod_v_reg) + (PRODV_W + 1)'(HALF_Q16);
        pu    = sum_u[PRODU_W:FRAC_Q16];
        pv    = sum_v[PRODV_W:FRAC_Q16];
        if (sum_u[PRODU_W])
            sx = '0;
        else if (CMPU_W'(pu) > CMPU_W'(wm1))
            sx = XIDX_W'(wm1);
        else
            sx = XIDX_W'(pu);
        if (sum_v[PRODV_W])
            sy = '0;
        else if (CMPV_W'(pv) > CMPV_W'(hm1))
            sy = YIDX_W'(hm1);
        else
            sy = YIDX_W'(pv);
    end

    // Step two: pick the pixel and test it against the active area.
    always_comb
    begin
        pix_inside = (req_q.pix_x >= 0) && (req_q.pix_x < $signed({1'b0, eff_w}))
            && (req_q.pix_y >= 0) && (req_q.pix_y < $signed({1'b0, eff_h}));
        if (req_q.req_type == REQ_SAMPLE)
        begin
            x_next      = sx;
            y_next      = sy;
            inside_next = 1'b1;
        end
        else
        begin
            x_next      = XIDX_W'(req_q.pix_x);
            y_next      = YIDX_W'(req_q.pix_y);
            inside_next = pix_inside;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.coord_en)
        begin
            x_reg      <= x_next;
            y_reg      <= y_next;
            inside_reg <= inside_next;
        end
    end

    // Step three: row-major address with the active width as stride.
    assign addr_full = AFULL_W'(y_reg) * AFULL_W'(eff_w) + AFULL_W'(x_reg);

    always_ff @(posedge clk)
    begin
        if (ctl.addr_en)
            addr_reg <= addr_full[STORE_AW-1:0];
    end

    assign res.addr    = addr_reg;
    assign res.in_area = inside_reg;

endmodule

FILE: hw/rtl/dbtw_store.sv
// Depth store: single-port synchronous memory with registered read data.
module dbtw_store
    import dbtw_pkg::*;
(
    input  logic               clk,
    input  mem_ctl_t           ctl,
    output logic [DEPTH_W-1:0] rd_data
);
    logic [DEPTH_W-1:0] mem [STORE_DEPTH];
    logic [DEPTH_W-1:0] rd_data_reg;

    // One access per cycle, either a write or a read.
    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
            mem[ctl.addr] <= ctl.wr_data;
        if (ctl.rd_en)
            rd_data_reg <= mem[ctl.addr];
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: hw/rtl/depth_buffer_test_write.sv
// Depth buffer with a less-than depth test on write; top level and sequencer.
// A read, sample or test-write passes the map steps, the store read and the done state in turn;
// its result is then registered, and no new request is taken until it has left the done state.
// The shared store port and the map, read and write-back steps serve one transaction at a time.
// A clear sweeps the store one entry a cycle, then gives its result.
// After reset the same sweep loads 1.0 into every entry; no request is taken.
module depth_buffer_test_write
    import dbtw_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    dbtw_req_if.sink              req,
    dbtw_rsp_if.source            rsp,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);
    typedef enum logic [7:0] {
        S_INIT  = 8'b0000_0001,
        S_IDLE  = 8'b0000_0010,
        S_MUL   = 8'b0000_0100,
        S_COORD = 8'b0000_1000,
        S_ADDR  = 8'b0001_0000,
        S_READ  = 8'b0010_0000,
        S_DONE  = 8'b0100_0000,
        S_CLEAR = 8'b1000_0000
    } state_t;

    localparam logic [STORE_AW-1:0] PTR_LAST = STORE_AW'(STORE_DEPTH - 1);

    state_t              state_reg;
    state_t              state_next;
    logic [CFG_DIM_W-1:0] width_reg;
    logic [CFG_DIM_W-1:0] height_reg;
    logic [DEPTH_W-1:0]  clear_depth_reg;
    logic [STORE_AW-1:0] clr_ptr_reg;
    logic [STORE_AW-1:0] clr_ptr_next;
    req_pkt_t            req_q_reg;
    logic [XDIM_W-1:0]   eff_w;
    logic [YDIM_W-1:0]   eff_h;
    map_ctl_t            map_ctl;
    map_res_t            map_res;
    mem_ctl_t            mem_ctl;
    logic [DEPTH_W-1:0]  rd_data;
    logic                accept;
    logic                fire;
    logic                ptr_at_end;
    logic                pass;
    logic                rsp_valid_reg;
    logic [DEPTH_W-1:0]  depth_out_reg;
    logic [DEPTH_W-1:0]  depth_out_next;
    logic                write_done_reg;
    logic                pixel_in_range_reg;
    logic                pixel_in_range_next;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg       <= CFG_DIM_W'(512);
            height_reg      <= CFG_DIM_W'(512);
            clear_depth_reg <= DEPTH_ONE;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_WIDTH_IN_USE:  width_reg       <= cfg_data[CFG_DIM_W-1:0];
                CFG_HEIGHT_IN_USE: height_reg      <= cfg_data[CFG_DIM_W-1:0];
                CFG_CLEAR_DEPTH:   clear_depth_reg <= cfg_data[DEPTH_W-1:0];
                default:           ;
            endcase
        end
    end

    // Effective geometry, clamped to 1..MAX.
    always_comb
    begin
        if (width_reg == '0)
            eff_w = XDIM_W'(1);
        else if (32'(width_reg) > MAX_WIDTH)
            eff_w = XDIM_W'(MAX_WIDTH);
        else
            eff_w = XDIM_W'(width_reg);
        if (height_reg == '0)
            eff_h = YDIM_W'(1);
        else if (32'(height_reg) > MAX_HEIGHT)
            eff_h = YDIM_W'(MAX_HEIGHT);
        else
            eff_h = YDIM_W'(height_reg);
    end

    assign req.ready  = (state_reg == S_IDLE);
    assign accept     = req.valid && req.ready;
    assign fire       = (state_reg == S_DONE) && (!rsp_valid_reg || rsp.ready);
    assign ptr_at_end = (clr_ptr_reg == PTR_LAST);

    // Hold the accepted transaction for the whole of its processing.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_q_reg.req_type <= req.req_type;
            req_q_reg.pix_x    <= req.pix_x;
            req_q_reg.pix_y    <= req.pix_y;
            req_q_reg.depth_in <= req.depth_in;
            req_q_reg.coord_u  <= req.coord_u;
            req_q_reg.coord_v  <= req.coord_v;
        end
    end

    // Sequencer.
    always_comb
    begin
        state_next   = state_reg;
        clr_ptr_next = clr_ptr_reg;
        unique case (state_reg)
            S_INIT:
            begin
                clr_ptr_next = clr_ptr_reg + STORE_AW'(1);
                if (ptr_at_end)
                begin
                    clr_ptr_next = '0;
                    state_next   = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                    state_next = (req.req_type == REQ_CLEAR) ? S_CLEAR : S_MUL;
            end
            S_MUL:   state_next = S_COORD;
            S_COORD: state_next = S_ADDR;
            S_ADDR:  state_next = S_READ;
            S_READ:  state_next = S_DONE;
            S_DONE:
            begin
                if (fire)
                    state_next = S_IDLE;
            end
            S_CLEAR:
            begin
                clr_ptr_next = clr_ptr_reg + STORE_AW'(1);
                if (ptr_at_end)
                begin
                    clr_ptr_next = '0;
                    state_next   = S_DONE;
                end
            end
            default: state_next = S_INIT;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_INIT;
            clr_ptr_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_ptr_reg <= clr_ptr_next;
        end
    end

    // Address mapping steps.
    assign map_ctl.mul_en   = (state_reg == S_MUL);
    assign map_ctl.coord_en = (state_reg == S_COORD);
    assign map_ctl.addr_en  = (state_reg == S_ADDR);

    dbtw_map u_map (
        .clk   (clk),
        .ctl   (map_ctl),
        .req_q (req_q_reg),
        .eff_w (eff_w),
        .eff_h (eff_h),
        .res   (map_res)
    );

    // Depth test: in range, 0..1.0 and strictly below the stored depth.
    assign pass = (req_q_reg.req_type == REQ_WRITE) && map_res.in_area
        && !req_q_reg.depth_in[DIN_W-1]
        && (req_q_reg.depth_in[DEPTH_W-1:0] <= DEPTH_ONE)
        && (req_q_reg.depth_in[DEPTH_W-1:0] < rd_data);

    // Store port: sweeps, the read, and the write-back of a passing test.
    always_comb
    begin
        mem_ctl = '0;
        unique case (state_reg)
            S_INIT:
            begin
                mem_ctl.wr_en   = 1'b1;
                mem_ctl.addr    = clr_ptr_reg;
                mem_ctl.wr_data = DEPTH_ONE;
            end
            S_CLEAR:
            begin
                mem_ctl.wr_en   = 1'b1;
                mem_ctl.addr    = clr_ptr_reg;
                mem_ctl.wr_data = clear_depth_reg;
            end
            S_READ:
            begin
                mem_ctl.rd_en = 1'b1;
                mem_ctl.addr  = map_res.addr;
            end
            S_DONE:
            begin
                mem_ctl.wr_en   = fire && pass;
                mem_ctl.addr    = map_res.addr;
                mem_ctl.wr_data = req_q_reg.depth_in[DEPTH_W-1:0];
            end
            default: ;
        endcase
    end

    dbtw_store u_store (
        .clk     (clk),
        .ctl     (mem_ctl),
        .rd_data (rd_data)
    );

    // Result fields by request type.
    always_comb
    begin
        depth_out_next      = '0;
        pixel_in_range_next = 1'b0;
        case (req_q_reg.req_type)
            REQ_WRITE:
            begin
                pixel_in_range_next = map_res.in_area;
            end
            REQ_READ:
            begin
                pixel_in_range_next = map_res.in_area;
                depth_out_next      = map_res.in_area ? rd_data : clear_depth_reg;
            end
            REQ_SAMPLE:
            begin
                pixel_in_range_next = 1'b1;
                depth_out_next      = (rd_data == clear_depth_reg) ? '0 : rd_data;
            end
            default: ;
        endcase
    end

    // Output register; the next transaction may enter while it waits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_valid_reg <= 1'b0;
        else if (fire)
            rsp_valid_reg <= 1'b1;
        else if (rsp.ready)
            rsp_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            depth_out_reg      <= depth_out_next;
            write_done_reg     <= pass;
            pixel_in_range_reg <= pixel_in_range_next;
        end
    end

    assign rsp.valid          = rsp_valid_reg;
    assign rsp.depth_out      = depth_out_reg;
    assign rsp.write_done     = write_done_reg;
    assign rsp.pixel_in_range = pixel_in_range_reg;

endmodule

FILE: hw/rtl/dbtw_checker.sv
// Port-level checks of the depth buffer block, bound to the top level.
module dbtw_checker
    import dbtw_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               req_valid,
    input logic               req_ready,
    input logic               rsp_valid,
    input logic               rsp_ready,
    input logic [DEPTH_W-1:0] rsp_depth_out,
    input logic               rsp_write_done,
    input logic               rsp_pixel_in_range
);
    // A response stays offered until it is taken.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("response dropped before it was taken");

    // A stored depth implies the pixel was inside the active area.
    a_done_inside: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_write_done |-> rsp_pixel_in_range)
        else $error("write done outside the active area");

    // A test-write result carries no depth.
    a_done_no_depth: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_write_done |-> rsp_depth_out == '0)
        else $error("write done with a nonzero depth");

    // One transaction at a time: the request side closes after an acceptance.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while another is in progress");
endmodule

bind depth_buffer_test_write dbtw_checker u_dbtw_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .req_valid          (req.valid),
    .req_ready          (req.ready),
    .rsp_valid          (rsp.valid),
    .rsp_ready          (rsp.ready),
    .rsp_depth_out      (rsp.depth_out),
    .rsp_write_done     (rsp.write_done),
    .rsp_pixel_in_range (rsp.pixel_in_range)
);

FILE: dv/tb_depth_buffer_test_write.sv
// Self-checking testbench for the depth buffer block with the less-than write test.
module tb_depth_buffer_test_write;
    import dbtw_pkg::*;

    localparam int CLK_HALF    = 6;
    localparam int RESET_CYC   = 7;
    // Longest quiet stretch allowed; the sweep after reset or a clear covers the whole store.
    localparam int QUIET_LIMIT = 1000000;
    // Cycles to watch for stray results once every expected result has come.
    localparam int SETTLE_CYC  = 12;

    typedef struct packed {
        logic [DEPTH_W-1:0] depth_out;
        logic               write_done;
        logic               pixel_in_range;
    } depth_result_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    dbtw_req_if req_ch ();
    dbtw_rsp_if rsp_ch ();

    depth_buffer_test_write DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Shadow copy of the depth store and of the configuration registers.
    logic [DEPTH_W-1:0]   depth_shadow [STORE_DEPTH];
    logic [CFG_DIM_W-1:0] width_shadow  = 10'd512;
    logic [CFG_DIM_W-1:0] height_shadow = 10'd512;
    logic [DEPTH_W-1:0]   clear_shadow  = DEPTH_ONE;

    depth_result_t pending_results [$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int fail_count     = 0;
    int requests_sent  = 0;
    int results_seen   = 0;
    int writes_stored  = 0;
    int clears_sent    = 0;
    int geometry_count = 1;
    int quiet_cycles   = 0;

    always #(CLK_HALF) clk = ~clk;

    // Effective dimension: the register clamped to 1..limit.
    function automatic int active_dim(input logic [CFG_DIM_W-1:0] v, input int limit);
        if (v == 0)
            return 1;
        if (int'(v) > limit)
            return limit;
        return int'(v);
    endfunction

    // Linear store index of a pixel, or -1 when it lies outside the area.
    function automatic int store_index(input int x, input int y, input int w, input int h);
        if (x >= 0 && x < w && y >= 0 && y < h)
            return y * w + x;
        return -1;
    endfunction

    // Q16 coordinate to pixel: round to nearest with ties up, then clamp.
    function automatic int sample_pixel(input logic signed [COORD_W-1:0] c, input int dim);
        longint s;
        longint p;
        s = longint'(c) * (dim - 1) + HALF_Q16;
        if (s < 0)
            return 0;
        p = s >>> FRAC_Q16;
        if (p > dim - 1)
            p = dim - 1;
        return int'(p);
    endfunction

    // Works out the result of one accepted request and updates the shadow store.
    function automatic depth_result_t predict_depth_result(input req_pkt_t item);
        depth_result_t res;
        int            w;
        int            h;
        int            idx;
        longint        d;
        logic [DEPTH_W-1:0] entry;
        w   = active_dim(width_shadow, MAX_WIDTH);
        h   = active_dim(height_shadow, MAX_HEIGHT);
        idx = store_index($signed(item.pix_x), $signed(item.pix_y), w, h);
        res = '0;
        case (item.req_type)
            REQ_WRITE:
            begin
                d = $signed(item.depth_in);
                res.pixel_in_range = (idx >= 0);
                if (idx >= 0 && d >= 0 && d <= longint'(DEPTH_ONE) &&
                    d < longint'(depth_shadow[idx]))
                begin
                    depth_shadow[idx] = DEPTH_W'(d);
                    res.write_done = 1'b1;
                    writes_stored++;
                end
            end
            REQ_READ:
            begin
                res.pixel_in_range = (idx >= 0);
                res.depth_out = (idx >= 0) ? depth_shadow[idx] : clear_shadow;
            end
            REQ_SAMPLE:
            begin
                entry = depth_shadow[sample_pixel($signed(item.coord_v), h) * w +
                                     sample_pixel($signed(item.coord_u), w)];
                res.depth_out = (entry == clear_shadow) ? '0 : entry;
                res.pixel_in_range = 1'b1;
            end
            default:
            begin
                // The clear covers the whole store, not only the active area.
                foreach (depth_shadow[i])
                    depth_shadow[i] = clear_shadow;
            end
        endcase
        return res;
    endfunction

    function automatic req_pkt_t make_item(input logic [REQ_W-1:0] kind, input int x,
                                           input int y, input longint d, input int u,
                                           input int v);
        req_pkt_t item;
        item.req_type = kind;
        item.pix_x    = PIX_W'(x);
        item.pix_y    = PIX_W'(y);
        item.depth_in = DIN_W'(d);
        item.coord_u  = COORD_W'(u);
        item.coord_v  = COORD_W'(v);
        return item;
    endfunction

    // A coordinate on or just past the border of a dimension.
    function automatic int border_value(input int n);
        case ($urandom_range(3))
            0: return -1;
            1: return n;
            2: return n - 1;
            default: return 0;
        endcase
    endfunction

    // Sample coordinate: mostly within 0..1.0, some just outside, some any value.
    function automatic logic signed [COORD_W-1:0] random_coord(
        input logic signed [COORD_W-1:0] noise);
        int pick;
        pick = $urandom_range(9);
        if (pick < 7)
            return COORD_W'($urandom_range(0, 65536));
        if (pick == 7)
            return COORD_W'(-int'($urandom_range(1, 4096)));
        if (pick == 8)
            return COORD_W'(65536 + int'($urandom_range(1, 4096)));
        return noise;
    endfunction

    function automatic req_pkt_t make_random_request();
        req_pkt_t item;
        int       w;
        int       h;
        int       idx;
        int       pick;
        longint   d;
        longint   top;
        w = active_dim(width_shadow, MAX_WIDTH);
        h = active_dim(height_shadow, MAX_HEIGHT);
        // Fields the request does not use carry random bits all the same.
        item.pix_x    = PIX_W'($urandom);
        item.pix_y    = PIX_W'($urandom);
        item.depth_in = DIN_W'($urandom);
        item.coord_u  = COORD_W'($urandom);
        item.coord_v  = COORD_W'($urandom);
        pick = $urandom_range(99);
        if (pick < 45)
            item.req_type = REQ_WRITE;
        else if (pick < 70)
            item.req_type = REQ_READ;
        else
            item.req_type = REQ_SAMPLE;

        if (item.req_type == REQ_SAMPLE)
        begin
            item.coord_u = random_coord(item.coord_u);
            item.coord_v = random_coord(item.coord_v);
            return item;
        end

        // Pixel: mostly inside the area, some on its border, the rest anywhere.
        pick = $urandom_range(9);
        if (pick < 8)
        begin
            item.pix_x = PIX_W'($urandom_range(0, w - 1));
            item.pix_y = PIX_W'($urandom_range(0, h - 1));
        end
        else if (pick == 8)
        begin
            item.pix_x = PIX_W'(border_value(w));
            item.pix_y = PIX_W'(border_value(h));
        end

        if (item.req_type == REQ_WRITE)
        begin
            idx  = store_index($signed(item.pix_x), $signed(item.pix_y), w, h);
            pick = $urandom_range(9);
            if (pick < 5)
                item.depth_in = DIN_W'($urandom_range(0, DEPTH_ONE));
            else if (pick < 7)
            begin
                // Just below the stored depth, so that most of these pass.
                top = (idx >= 0) ? longint'(depth_shadow[idx]) : longint'(DEPTH_ONE);
                if (top > longint'(DEPTH_ONE))
                    top = longint'(DEPTH_ONE) + 1;
                d = top - $urandom_range(1, 4096);
                item.depth_in = DIN_W'((d < 0) ? 0 : d);
            end
            else if (pick == 7)
            begin
                case ($urandom_range(3))
                    0: d = 0;
                    1: d = longint'(DEPTH_ONE);
                    2: d = longint'(DEPTH_ONE) + 1;
                    default: d = -1;
                endcase
                item.depth_in = DIN_W'(d);
            end
        end
        return item;
    endfunction

    // Offers one request, waits for its transaction and records the expected result.
    task automatic send_request(input req_pkt_t item);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.req_type <= item.req_type;
        req_ch.pix_x    <= item.pix_x;
        req_ch.pix_y    <= item.pix_y;
        req_ch.depth_in <= item.depth_in;
        req_ch.coord_u  <= item.coord_u;
        req_ch.coord_v  <= item.coord_v;
        @(posedge clk);
        while (req_ch.ready !== 1'b1)
            @(posedge clk);
        pending_results.push_back(predict_depth_result(item));
        requests_sent++;
        if (item.req_type == REQ_CLEAR)
            clears_sent++;
    endtask

    // Stops offering requests and waits until every expected result has come.
    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (index)
            CFG_WIDTH_IN_USE:  width_shadow  = data[CFG_DIM_W-1:0];
            CFG_HEIGHT_IN_USE: height_shadow = data[CFG_DIM_W-1:0];
            CFG_CLEAR_DEPTH:   clear_shadow  = data[DEPTH_W-1:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    // Registers change only once the block has gone idle.
    task automatic configure(input int w, input int h, input longint marker);
        wait_drained();
        write_reg(CFG_WIDTH_IN_USE, CFG_DATA_W'(w));
        write_reg(CFG_HEIGHT_IN_USE, CFG_DATA_W'(h));
        write_reg(CFG_CLEAR_DEPTH, CFG_DATA_W'(marker));
        geometry_count++;
    endtask

    task automatic set_idling(input int sender_pct, input int receiver_pct);
        send_idle_pct  = sender_pct;
        recv_stall_pct = receiver_pct;
    endtask

    task automatic run_random_traffic(input int count);
        repeat (count)
            send_request(make_random_request());
    endtask

    // Untouched entries after reset, and reads outside the area.
    task automatic test_reset_contents();
        send_request(make_item(REQ_SAMPLE, 0, 0, 0, 0, 0));
        send_request(make_item(REQ_READ, 0, 0, 0, 0, 0));
        send_request(make_item(REQ_READ, -1, 0, 0, 0, 0));
        send_request(make_item(REQ_READ, 512, 0, 0, 0, 0));
        send_request(make_item(REQ_READ, 2047, -2048, 0, 0, 0));
    endtask

    // Depth test: equal to stored, below it, negative, above 1.0, field extremes.
    task automatic test_write_rules();
        send_request(make_item(REQ_WRITE, 0, 0, DEPTH_ONE, 0, 0));
        send_request(make_item(REQ_WRITE, 0, 0, 0, 0, 0));
        send_request(make_item(REQ_WRITE, 511, 511, DEPTH_ONE - 1, 0, 0));
        send_request(make_item(REQ_WRITE, 511, 511, -1, 0, 0));
        send_request(make_item(REQ_WRITE, 5, 5, longint'(DEPTH_ONE) + 1, 0, 0));
        send_request(make_item(REQ_WRITE, 5, 5, -33554432, 0, 0));
        send_request(make_item(REQ_WRITE, 5, 5, 33554431, 0, 0));
        send_request(make_item(REQ_WRITE, -2048, 2047, 100, 0, 0));
    endtask

    // Sampling at the corners, with clamping of coordinates at both extremes.
    task automatic test_sample_mapping();
        send_request(make_item(REQ_SAMPLE, 0, 0, 0, 65536, 65536));
        send_request(make_item(REQ_SAMPLE, 0, 0, 0, -131072, 131071));
        send_request(make_item(REQ_SAMPLE, 0, 0, 0, 0, 0));
        send_request(make_item(REQ_READ, 511, 511, 0, 0, 0));
    endtask

    // Clear with the largest marker on a 3x3 area, then rounding ties when sampling.
    task automatic test_clear_and_ties();
        configure(3, 3, 33554431);
        send_request(make_item(REQ_CLEAR, 0, 0, 0, 0, 0));
        send_request(make_item(REQ_WRITE, 1, 0, 100, 0, 0));
        send_request(make_item(REQ_SAMPLE, 0, 0, 0, 16384, 0));
        send_request(make_item(REQ_SAMPLE, 0, 0, 0, 16383, 0));
        send_request(make_item(REQ_READ, 3, 0, 0, 0, 0));
        send_request(make_item(REQ_WRITE, 2, 2, DEPTH_ONE, 0, 0));
    endtask

    task automatic test_random_small_area();
        configure(8, 6, DEPTH_ONE);
        set_idling(24, 77);
        run_random_traffic(350);
    endtask

    // Width or height register at zero, the other at one or beyond the maximum.
    task automatic test_random_degenerate_geometry();
        configure(0, 1, DEPTH_ONE);
        run_random_traffic(125);
        configure(1023, 0, DEPTH_ONE);
        run_random_traffic(125);
    endtask

    task automatic test_random_full_area();
        configure(512, 512, 0);
        set_idling(77, 24);
        run_random_traffic(300);
    endtask

    task automatic test_random_after_clear();
        configure(37, 23, 12345678);
        set_idling(0, 0);
        send_request(make_item(REQ_CLEAR, $urandom_range(0, 36), $urandom_range(0, 22),
                               0, 0, 0));
        run_random_traffic(350);
    endtask

    // Response side: random stalls and a field by field check of each transaction.
    always @(posedge clk)
    begin
        depth_result_t got;
        depth_result_t want;
        if (rst_n === 1'b1)
        begin
            if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
            begin
                got.depth_out      = rsp_ch.depth_out;
                got.write_done     = rsp_ch.write_done;
                got.pixel_in_range = rsp_ch.pixel_in_range;
                results_seen++;
                if (pending_results.size() == 0)
                begin
                    $error("Unexpected result: depth_out %0d, write_done %0b, pixel_in_range %0b",
                           got.depth_out, got.write_done, got.pixel_in_range);
                    fail_count++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (got.depth_out !== want.depth_out)
                    begin
                        $error("depth_out: expected %0d, got %0d", want.depth_out,
                               got.depth_out);
                        fail_count++;
                    end
                    if (got.write_done !== want.write_done)
                    begin
                        $error("write_done: expected %0b, got %0b", want.write_done,
                               got.write_done);
                        fail_count++;
                    end
                    if (got.pixel_in_range !== want.pixel_in_range)
                    begin
                        $error("pixel_in_range: expected %0b, got %0b",
                               want.pixel_in_range, got.pixel_in_range);
                        fail_count++;
                    end
                end
            end
            rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog: ends the run after too long without any transaction.
    always @(posedge clk)
    begin
        if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
            (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $error("No transaction for %0d cycles, %0d results outstanding",
                   QUIET_LIMIT, pending_results.size());
            $display("FAILURE");
            $finish;
        end
    end

    initial
    begin
        rst_n           = 1'b0;
        req_ch.valid    = 1'b0;
        req_ch.req_type = REQ_WRITE;
        req_ch.pix_x    = '0;
        req_ch.pix_y    = '0;
        req_ch.depth_in = '0;
        req_ch.coord_u  = '0;
        req_ch.coord_v  = '0;
        rsp_ch.ready    = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = CFG_WIDTH_IN_USE;
        cfg_data        = '0;
        foreach (depth_shadow[i])
            depth_shadow[i] = DEPTH_ONE;
        repeat (RESET_CYC) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_contents();
        test_write_rules();
        test_sample_mapping();
        test_clear_and_ties();
        test_random_small_area();
        test_random_degenerate_geometry();
        test_random_full_area();
        test_random_after_clear();

        // Let any stray result show up before the verdict.
        wait_drained();
        repeat (SETTLE_CYC) @(posedge clk);
        $display("Ran %0d requests (%0d clears, %0d depths stored) over %0d geometries,",
                 requests_sent, clears_sent, writes_stored, geometry_count);
        $display("with %0d results checked under three sender and receiver stall profiles.",
                 results_seen);
        if (fail_count == 0 && pending_results.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
